// File: rtl/load_store_queue_macros.svh
// assertion macros for the load/store queue
// used by the front and back modules; no other dependencies
`ifndef LOAD_STORE_QUEUE_MACROS_SVH
`define LOAD_STORE_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define LSQ_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define LSQ_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define LSQ_ASSERT_IMP(label, clk, rst, a, c, msg)
`define LSQ_ASSERT_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

// File: rtl/lsq_pkg.sv
// shared types and constants for the load/store queue
// no dependencies
`timescale 1ns / 1ps
package lsq_pkg;
  localparam int DEF_SLOTS     = 16;
  localparam int DEF_MEM_WORDS = 1024;
  localparam int DEF_TAGS      = 64;

  typedef enum logic [2:0] {
    ACT_INSERT  = 3'd0,
    ACT_CAPTURE = 3'd1,
    ACT_TICK    = 3'd2,
    ACT_FLUSH   = 3'd3,
    ACT_MEMWR   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_LOAD  = 2'd1,
    EV_STORE = 2'd2,
    EV_EXC   = 2'd3
  } event_t;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_LATENCY  = 1'b1;

  // one queued word from front to back
  typedef struct packed {
    logic [2:0]  action;
    logic        is_store;
    logic [5:0]  rob_tag;
    logic [6:0]  src1_tag;
    logic [31:0] src1_value;
    logic [6:0]  src2_tag;
    logic [31:0] src2_value;
    logic [31:0] offset;
    logic [31:0] cycle;
    logic [9:0]  mem_address;
  } cmd_t;
endpackage

// File: rtl/lsq_front.sv
// front end: accepts command words into a two-entry queue ahead of the back end
// depends on lsq_pkg and load_store_queue_macros.svh
`timescale 1ns / 1ps
`include "load_store_queue_macros.svh"
module lsq_front
  import lsq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic avail,
  output cmd_t head,
  output logic space
);
  cmd_t q [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign avail = (count != 2'd0);
  assign head  = q[rd_ptr];
  assign space = (count != 2'd2);

  // payload write
  always_ff @(posedge clk) begin
    if (push && space) q[wr_ptr] <= push_cmd;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && space) wr_ptr <= ~wr_ptr;
      if (pop && avail) rd_ptr <= ~rd_ptr;
      count <= count + 2'((push && space) ? 1 : 0) - 2'((pop && avail) ? 1 : 0);
    end
  end

  `LSQ_ASSERT_IMP(a_no_over, clk, rst, count == 2'd2, !(push && space), "queue overflow")
  `LSQ_ASSERT_NEXT(a_fill, clk, rst, push && space && !pop && count == 2'd0, count == 2'd1, "fill")
  `LSQ_ASSERT_IMP(a_lvl, clk, rst, 1'b1, count <= 2'd2, "count range")
endmodule

// File: rtl/lsq_back.sv
// back end: slot array, issue pipe, data memory, and result formation
// depends on lsq_pkg and load_store_queue_macros.svh
`timescale 1ns / 1ps
`include "load_store_queue_macros.svh"
module lsq_back
  import lsq_pkg::*;
#(
  parameter int SLOTS     = DEF_SLOTS,
  parameter int MEM_WORDS = DEF_MEM_WORDS
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        avail,
  input  cmd_t        cmd,
  output logic        pop,
  input  logic [4:0]  capacity,
  input  logic [3:0]  latency,
  output logic        done,
  output logic [1:0]  event_res,
  output logic [5:0]  done_tag,
  output logic [9:0]  address,
  output logic [31:0] value,
  output logic        full_res,
  output logic        dropped,
  output logic        ready
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [1:0] {S_CLEAR, S_EXEC, S_LOAD} bstate_t;
  bstate_t state, state_next;

  logic [SLOTS-1:0] slot_valid, slot_issued;
  logic             slot_is_store [SLOTS];
  logic [5:0]       slot_tag [SLOTS];
  logic [6:0]       slot_wait1 [SLOTS];
  logic [31:0]      slot_val1 [SLOTS];
  logic [6:0]       slot_wait2 [SLOTS];
  logic [31:0]      slot_val2 [SLOTS];
  logic [31:0]      slot_imm [SLOTS];
  logic [31:0]      slot_stamp [SLOTS];
  logic [5:0]       pipe_tag [SLOTS];
  logic [3:0]       pipe_rem [SLOTS];
  logic [CW-1:0]    pipe_count;
  logic [CW-1:0]    n;
  logic [31:0]      mem [MEM_WORDS];
  logic [31:0]      mem_rd;
  logic [AW-1:0]    clr_addr;

  // held result for a load awaiting memory read
  logic [5:0] hold_tag;
  logic [9:0] hold_addr;
  logic       hold_full;

  // occupancy as leading run of valid bits
  always_comb begin
    n = '0;
    for (int i = SLOTS - 1; i >= 0; i--) if (!slot_valid[i]) n = CW'(i);
    if (&slot_valid) n = CW'(SLOTS);
  end

  // oldest unissued and oldest issued slots
  logic [SW-1:0] iu, is_;
  logic          iu_ok, is_ok;
  always_comb begin
    iu = '0; iu_ok = 1'b0; is_ = '0; is_ok = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && !slot_issued[i]) begin iu = SW'(i); iu_ok = 1'b1; end
      if (slot_valid[i] && slot_issued[i]) begin is_ = SW'(i); is_ok = 1'b1; end
    end
  end

  logic act_ok;
  assign act_ok = (state == S_EXEC) && avail;
  logic is_tick;
  assign is_tick = act_ok && (cmd.action == ACT_TICK);

  logic do_issue;
  assign do_issue = is_tick && iu_ok && (slot_wait1[iu] == 7'h7f)
                    && (!slot_is_store[iu] || slot_wait2[iu] == 7'h7f)
                    && (slot_stamp[iu] < cmd.cycle) && (pipe_count < CW'(SLOTS));

  // pipe view after issue and decrement
  logic [3:0] rem0;
  always_comb begin
    rem0 = (pipe_count == '0) ? latency : pipe_rem[0];
    if (rem0 != 4'd0) rem0 = rem0 - 4'd1;
  end
  logic complete;
  assign complete = is_tick && ((pipe_count != '0) || do_issue) && (rem0 == 4'd0);
  logic [5:0] ctag;
  assign ctag = (pipe_count == '0) ? slot_tag[iu] : pipe_tag[0];

  // finished slot: oldest issued, including one issuing now
  logic [SW-1:0] fs;
  logic          fs_ok;
  always_comb begin
    if (is_ok && (!do_issue || is_ < iu)) begin fs = is_; fs_ok = 1'b1; end
    else if (do_issue) begin fs = iu; fs_ok = 1'b1; end
    else begin fs = '0; fs_ok = 1'b0; end
  end
  logic signed [32:0] addr_s;
  assign addr_s = (slot_is_store[fs] ? {slot_val2[fs][31], slot_val2[fs]}
                                     : {slot_val1[fs][31], slot_val1[fs]})
                  + {slot_imm[fs][31], slot_imm[fs]};
  logic addr_bad;
  assign addr_bad = (addr_s < 0) || (addr_s >= 33'(MEM_WORDS));
  logic [CW-1:0] n_after;
  always_comb begin
    n_after = n;
    if (act_ok && cmd.action == ACT_INSERT && n != CW'(SLOTS)) n_after = n + 1'b1;
    if (complete && fs_ok) n_after = n - 1'b1;
    if (act_ok && cmd.action == ACT_FLUSH) n_after = '0;
  end
  logic full_now;
  assign full_now = ({1'b0, n_after} >= (CW+1)'(capacity)) | (capacity == 5'd0);

  // control
  always_comb begin
    state_next = state;
    pop = 1'b0;
    unique case (state)
      S_CLEAR: if (clr_addr == AW'(MEM_WORDS - 1)) state_next = S_EXEC;
      S_EXEC: begin
        pop = avail;
        if (complete && fs_ok && !addr_bad && !slot_is_store[fs]) state_next = S_LOAD;
      end
      S_LOAD: state_next = S_EXEC;
      default: state_next = S_EXEC;
    endcase
  end
  assign ready = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  // data memory: clear sweep, writes, registered read
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) mem[clr_addr] <= '0;
    else if (act_ok && cmd.action == ACT_MEMWR && 32'(cmd.mem_address) < 32'(MEM_WORDS))
      mem[AW'(cmd.mem_address)] <= cmd.src1_value;
    mem_rd <= mem[AW'(addr_s)];
  end

  // slot and pipe state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_issued <= '0;
      pipe_count <= '0;
    end else if (act_ok) begin
      unique case (cmd.action)
        ACT_INSERT: if (n != CW'(SLOTS)) begin
          slot_valid[SW'(n)] <= 1'b1;
          slot_issued[SW'(n)] <= 1'b0;
          slot_is_store[SW'(n)] <= cmd.is_store;
          slot_tag[SW'(n)] <= cmd.rob_tag;
          slot_wait1[SW'(n)] <= cmd.src1_tag;
          slot_val1[SW'(n)] <= cmd.src1_value;
          slot_wait2[SW'(n)] <= cmd.src2_tag;
          slot_val2[SW'(n)] <= cmd.src2_value;
          slot_imm[SW'(n)] <= cmd.offset;
          slot_stamp[SW'(n)] <= cmd.cycle;
        end
        ACT_CAPTURE: for (int i = 0; i < SLOTS; i++) if (CW'(i) < n) begin
          if (slot_wait1[i] == {1'b0, cmd.rob_tag}) begin
            slot_wait1[i] <= 7'h7f; slot_val1[i] <= cmd.src1_value;
          end
          if (slot_wait2[i] == {1'b0, cmd.rob_tag}) begin
            slot_wait2[i] <= 7'h7f; slot_val2[i] <= cmd.src1_value;
          end
        end
        ACT_TICK: begin
          // pipe: decrement, append, pop head on completion
          for (int i = 0; i < SLOTS; i++) begin
            logic [3:0] r;
            logic [3:0] rn;
            logic [5:0] tn;
            r = (CW'(i) == pipe_count) ? latency : pipe_rem[i];
            if (r != 4'd0) r = r - 4'd1;
            if (i + 1 < SLOTS) begin
              rn = (CW'(i + 1) == pipe_count) ? latency : pipe_rem[i + 1];
              if (rn != 4'd0) rn = rn - 4'd1;
              tn = (CW'(i + 1) == pipe_count) ? slot_tag[iu] : pipe_tag[i + 1];
            end else begin
              rn = r; tn = pipe_tag[i];
            end
            if (complete) begin
              pipe_rem[i] <= rn; pipe_tag[i] <= tn;
            end else begin
              pipe_rem[i] <= r;
              if (CW'(i) == pipe_count && do_issue) pipe_tag[i] <= slot_tag[iu];
            end
          end
          pipe_count <= pipe_count + CW'(do_issue) - CW'(complete);
          // slots: mark issue, then remove finished slot with shift
          for (int i = 0; i < SLOTS; i++) begin
            logic iss;
            iss = slot_issued[i] | (do_issue && SW'(i) == iu);
            if (complete && fs_ok && SW'(i) >= fs) begin
              if (i + 1 < SLOTS && CW'(i + 1) < n) begin
                slot_issued[i] <= slot_issued[i + 1] | (do_issue && SW'(i + 1) == iu);
                slot_is_store[i] <= slot_is_store[i + 1];
                slot_tag[i] <= slot_tag[i + 1];
                slot_wait1[i] <= slot_wait1[i + 1];
                slot_val1[i] <= slot_val1[i + 1];
                slot_wait2[i] <= slot_wait2[i + 1];
                slot_val2[i] <= slot_val2[i + 1];
                slot_imm[i] <= slot_imm[i + 1];
                slot_stamp[i] <= slot_stamp[i + 1];
              end else if (CW'(i + 1) == n) begin
                slot_valid[i] <= 1'b0; slot_issued[i] <= 1'b0;
              end
            end else begin
              slot_issued[i] <= iss;
            end
          end
        end
        ACT_FLUSH: begin
          slot_valid <= '0; slot_issued <= '0; pipe_count <= '0;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == S_LOAD) begin
        done <= 1'b1; event_res <= EV_LOAD; done_tag <= hold_tag;
        address <= hold_addr; value <= mem_rd; full_res <= hold_full; dropped <= 1'b0;
      end else if (act_ok) begin
        hold_tag <= ctag; hold_addr <= 10'(addr_s); hold_full <= full_now;
        done <= !(complete && fs_ok && !addr_bad && !slot_is_store[fs]);
        event_res <= EV_NONE; done_tag <= '0; address <= '0; value <= '0;
        full_res <= full_now;
        dropped <= (cmd.action == ACT_INSERT) && (n == CW'(SLOTS));
        if (complete) begin
          done_tag <= ctag;
          if (!fs_ok || addr_bad) event_res <= EV_EXC;
          else if (slot_is_store[fs]) begin
            event_res <= EV_STORE; address <= 10'(addr_s); value <= slot_val1[fs];
          end
        end
      end
    end
  end

  `LSQ_ASSERT_IMP(a_pipe, clk, rst, 1'b1, pipe_count <= CW'(SLOTS), "pipe overflow")
  `LSQ_ASSERT_NEXT(a_load, clk, rst, state == S_LOAD, done, "load result lost")
  `LSQ_ASSERT_IMP(a_pop, clk, rst, pop, state == S_EXEC, "pop outside exec")
endmodule

// File: rtl/load_store_queue.sv
// load/store queue top level: config registers, command queue, execution back end
// depends on lsq_pkg, lsq_front, lsq_back
//
//  channel | signals                               | handshake
//  command | start/busy + payload fields          | taken when start && !busy
//  config  | cfg_we, cfg_index, cfg_data           | written when cfg_we
//  result  | done + event_res..dropped             | one cycle strobe, no stall
//
// an item passes the command queue register and the back end's result register;
// a load that completes also passes S_LOAD for the registered data memory read.
// after reset the data memory is cleared word by word in S_CLEAR; busy stays high.
// results cannot be held off by the receiver.
`timescale 1ns / 1ps
module load_store_queue
  import lsq_pkg::*;
#(
  parameter int SLOTS     = DEF_SLOTS,
  parameter int MEM_WORDS = DEF_MEM_WORDS
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic        is_store,
  input  logic [5:0]  rob_tag,
  input  logic signed [6:0]  src1_tag,
  input  logic signed [31:0] src1_value,
  input  logic signed [6:0]  src2_tag,
  input  logic signed [31:0] src2_value,
  input  logic signed [31:0] offset,
  input  logic [31:0] cycle,
  input  logic [9:0]  mem_address,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  output logic        done,
  output logic [1:0]  event_res,
  output logic [5:0]  done_tag,
  output logic [9:0]  address,
  output logic signed [31:0] value,
  output logic        full_res,
  output logic        dropped
);
  logic [4:0] capacity;
  logic [3:0] latency;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 5'd16;
      latency  <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: capacity <= cfg_data;
        CFG_LATENCY:  latency  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  cmd_t in_cmd, head;
  logic avail, space, pop, bready;
  assign in_cmd = '{action, is_store, rob_tag, src1_tag, src1_value, src2_tag,
                    src2_value, offset, cycle, mem_address};
  assign busy = !space || !bready;

  lsq_front u_front (
    .clk(clk), .rst(rst), .push(start && !busy), .push_cmd(in_cmd),
    .pop(pop), .avail(avail), .head(head), .space(space)
  );

  lsq_back #(.SLOTS(SLOTS), .MEM_WORDS(MEM_WORDS)) u_back (
    .clk(clk), .rst(rst), .avail(avail), .cmd(head), .pop(pop),
    .capacity(capacity), .latency(latency), .done(done), .event_res(event_res),
    .done_tag(done_tag), .address(address), .value(value), .full_res(full_res),
    .dropped(dropped), .ready(bready)
  );
endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for the load/store queue: directed table, then random commands
// depends on lsq_pkg and load_store_queue; carries its own prediction of the queue
`timescale 1ns / 1ps
module tb_top;
  import lsq_pkg::*;

  localparam int NSLOT = 16;
  localparam int NWORD = 1024;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] action = ACT_FLUSH;
  logic is_store = 1'b0;
  logic [5:0] rob_tag = '0;
  logic signed [6:0] src1_tag = '0;
  logic signed [31:0] src1_value = '0;
  logic signed [6:0] src2_tag = '0;
  logic signed [31:0] src2_value = '0;
  logic signed [31:0] offset = '0;
  logic [31:0] cycle = '0;
  logic [9:0] mem_address = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_CAPACITY;
  logic [4:0] cfg_data = '0;
  logic done;
  logic [1:0] event_res;
  logic [5:0] done_tag;
  logic [9:0] address;
  logic signed [31:0] value;
  logic full_res;
  logic dropped;

  load_store_queue DUT (.*);

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  typedef struct packed {
    logic [1:0]  ev;
    logic [5:0]  tag;
    logic [9:0]  addr;
    logic [31:0] data;
    logic        full;
    logic        drop;
  } outcome_t;

  typedef struct packed {
    logic        is_st;
    logic [5:0]  tag;
    logic signed [6:0] w1;
    logic [31:0] v1;
    logic signed [6:0] w2;
    logic [31:0] v2;
    logic [31:0] imm;
    logic [31:0] stamp;
    logic        issued;
  } entry_t;

  // predicted queue state
  entry_t    q_entry[$];
  logic [5:0] pipe_tag_q[$];
  logic [4:0] pipe_left_q[$];
  logic [31:0] mem_img[NWORD];
  logic [4:0] cap_reg;
  logic [3:0] lat_reg;

  outcome_t  pending_q[$];
  int        mismatch_cnt = 0;
  int        words_seen = 0;
  int        cycle_cnt = 0;
  int        send_idle_pct = 0;
  int        tag_seq = 0;
  logic [31:0] now_cnt = 32'd10;

  function automatic outcome_t lsq_predict(cmd_t c);
    outcome_t r;
    entry_t e;
    int s;
    logic signed [63:0] a;
    r = '0;
    case (c.action)
      ACT_INSERT: begin
        if (q_entry.size() >= NSLOT) begin
          r.drop = 1'b1;
        end else begin
          e = '{c.is_store, c.rob_tag, c.src1_tag, c.src1_value,
                c.src2_tag, c.src2_value, c.offset, c.cycle, 1'b0};
          q_entry.insert(q_entry.size(), e);
        end
      end
      ACT_CAPTURE: begin
        foreach (q_entry[i]) begin
          if (q_entry[i].w1 == $signed({1'b0, c.rob_tag})) begin
            q_entry[i].w1 = -7'sd1;
            q_entry[i].v1 = c.src1_value;
          end
          if (q_entry[i].w2 == $signed({1'b0, c.rob_tag})) begin
            q_entry[i].w2 = -7'sd1;
            q_entry[i].v2 = c.src1_value;
          end
        end
      end
      ACT_TICK: begin
        // only the oldest unissued entry may go
        foreach (q_entry[i]) begin
          if (!q_entry[i].issued) begin
            if (q_entry[i].w1 == -7'sd1 && (!q_entry[i].is_st || q_entry[i].w2 == -7'sd1)
                && q_entry[i].stamp < c.cycle && pipe_tag_q.size() < NSLOT) begin
              q_entry[i].issued = 1'b1;
              pipe_tag_q.insert(pipe_tag_q.size(), q_entry[i].tag);
              pipe_left_q.insert(pipe_left_q.size(), {1'b0, lat_reg});
            end
            break;
          end
        end
        foreach (pipe_left_q[i]) if (pipe_left_q[i] != 0) pipe_left_q[i]--;
        if (pipe_tag_q.size() > 0 && pipe_left_q[0] == 0) begin
          r.tag = pipe_tag_q[0];
          pipe_tag_q.delete(0);
          pipe_left_q.delete(0);
          s = -1;
          foreach (q_entry[i]) if (s < 0 && q_entry[i].issued) s = i;
          r.ev = EV_EXC;
          if (s >= 0) begin
            a = q_entry[s].is_st ? 64'(signed'(q_entry[s].v2)) : 64'(signed'(q_entry[s].v1));
            a = a + 64'(signed'(q_entry[s].imm));
            if (a >= 0 && a < NWORD) begin
              r.addr = a[9:0];
              r.ev = q_entry[s].is_st ? EV_STORE : EV_LOAD;
              r.data = q_entry[s].is_st ? q_entry[s].v1 : mem_img[a[9:0]];
            end
            q_entry.delete(s);
          end
        end
      end
      ACT_FLUSH: begin
        q_entry.delete();
        pipe_tag_q.delete();
        pipe_left_q.delete();
      end
      ACT_MEMWR: mem_img[c.mem_address] = c.src1_value;
      default: ;
    endcase
    r.full = (q_entry.size() >= cap_reg);
    return r;
  endfunction

  // compare each strobed word with the oldest expectation
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst && done) begin
      got = '{event_res, done_tag, address, value, full_res, dropped};
      words_seen++;
      if (pending_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected word %p", got);
      end else begin
        want = pending_q[0];
        pending_q.delete(0);
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("word %0d expected %p got %p", words_seen, want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", pending_q.size());
      $display("load_store_queue: mismatch");
      $finish;
    end
  end

  // start stays high between back-to-back words and drops only while idling
  task automatic send_cmd(cmd_t c, bit typed, outcome_t typed_want);
    outcome_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    action <= c.action; is_store <= c.is_store; rob_tag <= c.rob_tag;
    src1_tag <= c.src1_tag; src1_value <= c.src1_value; src2_tag <= c.src2_tag;
    src2_value <= c.src2_value; offset <= c.offset; cycle <= c.cycle;
    mem_address <= c.mem_address;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = lsq_predict(c);
    pending_q.insert(pending_q.size(), typed ? typed_want : p);
  endtask

  task automatic drain_quiet();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] d);
    cfg_index <= idx; cfg_data <= d; cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CAPACITY) cap_reg = d; else lat_reg = d[3:0];
    @(posedge clk);
  endtask

  function automatic cmd_t mk(logic [2:0] act, logic st, logic [5:0] tg, logic signed [6:0] t1,
                              logic [31:0] v1, logic signed [6:0] t2, logic [31:0] v2,
                              logic [31:0] imm, logic [31:0] cyc, logic [9:0] ma);
    return '{act, st, tg, t1, v1, t2, v2, imm, cyc, ma};
  endfunction

  // random command, mostly well-formed traffic
  function automatic cmd_t rand_cmd();
    cmd_t c;
    logic [191:0] raw;
    int k;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(cmd_t)-1:0];
    k = $urandom_range(99);
    if (k < 35) begin
      c.action = ACT_INSERT;
      c.rob_tag = 6'(tag_seq++);
      c.src1_tag = ($urandom_range(3) == 0) ? 7'($urandom_range(63)) : -7'sd1;
      c.src2_tag = ($urandom_range(3) == 0) ? 7'($urandom_range(63)) : -7'sd1;
      if ($urandom_range(30) == 0) c.src1_tag = -7'sd5;
      c.cycle = now_cnt - 32'($urandom_range(2));
      if ($urandom_range(9) != 0) begin
        c.src1_value = $urandom_range(600);
        c.src2_value = $urandom_range(600);
        c.offset = 32'($signed($urandom_range(400)) - 100);
      end
    end else if (k < 45) begin
      c.action = ACT_CAPTURE;
      c.rob_tag = 6'($urandom_range(63));
    end else if (k < 88) begin
      c.action = ACT_TICK;
      now_cnt = now_cnt + 32'($urandom_range(2));
      c.cycle = ($urandom_range(40) == 0) ? c.cycle : now_cnt;
    end else if (k < 90) begin
      c.action = ACT_FLUSH;
    end else if (k < 98) begin
      c.action = ACT_MEMWR;
    end else begin
      c.action = 3'($urandom_range(7, 5));
    end
    return c;
  endfunction

  typedef struct {
    cmd_t     c;
    bit       typed;
    outcome_t want;
  } row_t;

  row_t rows[$];

  function automatic void add_row(cmd_t c, bit typed, outcome_t want);
    row_t r;
    r.c = c;
    r.typed = typed;
    r.want = want;
    rows.insert(rows.size(), r);
  endfunction

  initial begin
    outcome_t z;
    int phase;
    z = '0;
    cap_reg = 5'd16;
    lat_reg = 4'd1;
    foreach (mem_img[i]) mem_img[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed table: reset outcomes, extremes, exceptions, full queue with a dropped insert
    add_row(mk(ACT_TICK, 0, 0, -1, 0, -1, 0, 0, 32'hFFFFFFFF, 0), 1, z);
    add_row(mk(ACT_MEMWR, 0, 0, 0, 32'h80000000, 0, 0, 0, 0, 10'h3FF), 1, z);
    add_row(mk(ACT_MEMWR, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 10'h000), 1, z);
    add_row(mk(ACT_INSERT, 0, 63, -1, 1000, -1, 0, 23, 0, 0), 0, z);
    add_row(mk(ACT_TICK, 0, 0, -1, 0, -1, 0, 0, 1, 0), 0, z);
    add_row(mk(ACT_INSERT, 1, 1, -1, 32'h7FFFFFFF, -1, 32'h80000000, 32'h80000000,
               0, 0), 0, z);
    add_row(mk(ACT_TICK, 0, 0, -1, 0, -1, 0, 0, 2, 0), 1,
            '{EV_EXC, 6'd1, 10'd0, 32'd0, 1'b0, 1'b0});
    add_row(mk(ACT_INSERT, 0, 2, 63, 0, 0, 0, -5, 0, 0), 0, z);
    add_row(mk(ACT_CAPTURE, 0, 63, 0, 5, 0, 0, 0, 0, 0), 0, z);
    add_row(mk(ACT_TICK, 0, 0, -1, 0, -1, 0, 0, 3, 0), 1,
            '{EV_LOAD, 6'd2, 10'd0, 32'h7FFFFFFF, 1'b0, 1'b0});
    add_row(mk(ACT_INSERT, 0, 3, -64, 0, -1, 0, 0, 0, 0), 0, z);
    add_row(mk(ACT_TICK, 0, 0, -1, 0, -1, 0, 0, 4, 0), 0, z);
    add_row(mk(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z);
    add_row(mk(3'd7, 1, 63, 63, -1, 63, -1, -1, -1, 10'h3FF), 1, z);
    for (int i = 0; i < 17; i++)
      add_row(mk(ACT_INSERT, i[0], 6'(i), 63, 0, -1, 0, 0, 0, 0), 0, z);
    foreach (rows[i]) send_cmd(rows[i].c, rows[i].typed, rows[i].want);
    send_cmd(mk(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z);
    drain_quiet();

    // random phases under several register settings
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(CFG_CAPACITY, 5'd1);  write_reg(CFG_LATENCY, 5'd0);  end
        1: begin write_reg(CFG_CAPACITY, 5'd31); write_reg(CFG_LATENCY, 5'd15); end
        2: begin write_reg(CFG_CAPACITY, 5'd16); write_reg(CFG_LATENCY, 5'd3);  end
        3: begin write_reg(CFG_CAPACITY, 5'd8);  write_reg(CFG_LATENCY, 5'd1);  end
        4: begin write_reg(CFG_CAPACITY, 5'd4);  write_reg(CFG_LATENCY, 5'd2);  end
        default: begin write_reg(CFG_CAPACITY, 5'd12); write_reg(CFG_LATENCY, 5'd6); end
      endcase
      send_idle_pct = (phase < 2) ? 6 : (phase < 4) ? 62 : 0;
      for (int i = 0; i < 180; i++) send_cmd(rand_cmd(), 0, z);
      // lowering latency mid-flight is checked at the next phase boundary
      drain_quiet();
    end

    repeat (20) @(posedge clk);
    $display("ran %0d result words over 6 register settings, %0d mismatches",
             words_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_q.size() == 0) begin
      $display("load_store_queue: match");
    end else begin
      $display("load_store_queue: mismatch");
    end
    $finish;
  end
endmodule
